// ----- rtl/medsa_pkg.sv -----
`default_nettype none

package medsa_pkg;

   // Element and result widths
   localparam int VALUE_W  = 31;
   localparam int MEDIAN_W = 32;

   // Item action codes
   localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
   localparam logic [1:0] ACT_COMPUTE     = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_DROPPED = 2'd2;
   localparam logic [1:0] STAT_NO_PART = 2'd3;

   // Values seen past either end of an array
   localparam logic signed [MEDIAN_W-1:0] SENT_LO = -32'sd1000000000;
   localparam logic signed [MEDIAN_W-1:0] SENT_HI = 32'sd1000000000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CUT,
      ST_READ_L,
      ST_READ_R,
      ST_EVAL,
      ST_DONE
   } medsa_state_type;

   // Control from the search sequencer to the load side
   typedef struct packed {
      logic idle;
      logic clear;
   } medsa_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/medsa_store.sv -----
`default_nettype none

module medsa_store import medsa_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic signed [VALUE_W-1:0]  wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output logic signed [VALUE_W-1:0]       rd_data_ff
);

   logic signed [VALUE_W-1:0] mem [DEPTH];

   // Write one element
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read every cycle, data in the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/medsa_ctrl.sv -----
`default_nettype none

module medsa_ctrl import medsa_pkg::*; #(
   parameter int AW = 10,
   parameter int CW = 11
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [CW-1:0]              n_first,
   input  wire logic [CW-1:0]              n_second,
   input  wire logic                       dropped,
   output logic [AW-1:0]                   rd_addr_first,
   output logic [AW-1:0]                   rd_addr_second,
   input  wire logic signed [VALUE_W-1:0]  rd_data_first,
   input  wire logic signed [VALUE_W-1:0]  rd_data_second,
   output medsa_ctl_type                   ctl,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [MEDIAN_W-1:0]      rsp_median_doubled,
   output logic [1:0]                      rsp_status
);

   localparam int LW = CW + 1;

   medsa_state_type state_ff, state_in;

   logic                        sel_ff, sel_in;
   logic [CW-1:0]               half_ff, half_in;
   logic [LW-1:0]               lo_ff, lo_in;
   logic [LW-1:0]               hi_ff, hi_in;
   logic [CW-1:0]               c1_ff, c1_in;
   logic [CW-1:0]               c2_ff, c2_in;
   logic signed [VALUE_W-1:0]   left_short_ff, left_short_in;
   logic signed [VALUE_W-1:0]   left_long_ff, left_long_in;
   logic signed [MEDIAN_W-1:0]  res_med_ff, res_med_in;
   logic [1:0]                  res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [MEDIAN_W-1:0]  rsp_med_ff, rsp_med_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;

   logic [CW-1:0]               n_short, n_long;
   logic                        start_sel;
   logic [CW:0]                 total;
   logic [LW:0]                 cut_sum;
   logic [CW-1:0]               cut_mid;
   logic [AW-1:0]               short_addr, long_addr;
   logic signed [VALUE_W-1:0]   rd_short, rd_long;
   logic signed [MEDIAN_W-1:0]  l1, l2, r1, r2, mx, mn;
   logic signed [MEDIAN_W:0]    pair_sum;
   logic                        odd_total;

   // Pick the shorter array, the first one on a tie
   assign start_sel = (n_second < n_first);
   assign n_short   = sel_ff ? n_second : n_first;
   assign n_long    = sel_ff ? n_first : n_second;
   assign total     = {1'b0, n_first} + {1'b0, n_second} + (CW + 1)'(1);
   assign odd_total = n_first[0] ^ n_second[0];

   // Midpoint of the current bounds
   assign cut_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign cut_mid = CW'(cut_sum >> 1);

   // Left neighbors on the first read, right neighbors on the second
   assign short_addr = (state_ff == ST_READ_L) ? AW'(c1_ff - CW'(1)) : AW'(c1_ff);
   assign long_addr  = (state_ff == ST_READ_L) ? AW'(c2_ff - CW'(1)) : AW'(c2_ff);
   assign rd_addr_first  = sel_ff ? long_addr : short_addr;
   assign rd_addr_second = sel_ff ? short_addr : long_addr;
   assign rd_short = sel_ff ? rd_data_second : rd_data_first;
   assign rd_long  = sel_ff ? rd_data_first : rd_data_second;

   // Substitute sentinels past either end
   assign l1 = (c1_ff == '0 || c1_ff > n_short) ? SENT_LO : MEDIAN_W'(left_short_ff);
   assign l2 = (c2_ff == '0 || c2_ff > n_long) ? SENT_LO : MEDIAN_W'(left_long_ff);
   assign r1 = (c1_ff >= n_short) ? SENT_HI : MEDIAN_W'(rd_short);
   assign r2 = (c2_ff >= n_long) ? SENT_HI : MEDIAN_W'(rd_long);
   assign mx = (l1 > l2) ? l1 : l2;
   assign mn = (r1 < r2) ? r1 : r2;
   assign pair_sum = (MEDIAN_W + 1)'(mx) + (MEDIAN_W + 1)'(mn);

   // Sequence the search
   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      half_in       = half_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      left_short_in = left_short_ff;
      left_long_in  = left_long_ff;
      res_med_in    = res_med_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_med_in    = rsp_med_ff;
      rsp_status_in = rsp_status_ff;
      ctl.idle      = 1'b0;
      ctl.clear     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.idle = 1'b1;
            if (start) begin
               sel_in  = start_sel;
               half_in = CW'(total >> 1);
               lo_in   = '0;
               hi_in   = LW'(start_sel ? n_second : n_first);
               if (n_first == '0 && n_second == '0) begin
                  res_med_in    = '0;
                  res_status_in = STAT_EMPTY;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_CUT;
               end
            end
         end
         ST_CUT: begin
            if (lo_ff > hi_ff) begin
               res_med_in    = '0;
               res_status_in = STAT_NO_PART;
               state_in      = ST_DONE;
            end else begin
               c1_in    = cut_mid;
               c2_in    = half_ff - cut_mid;
               state_in = ST_READ_L;
            end
         end
         ST_READ_L: begin
            state_in = ST_READ_R;
         end
         ST_READ_R: begin
            left_short_in = rd_short;
            left_long_in  = rd_long;
            state_in      = ST_EVAL;
         end
         ST_EVAL: begin
            if (l1 <= r2 && l2 <= r1) begin
               res_med_in    = odd_total ? (mx <<< 1) : pair_sum[MEDIAN_W-1:0];
               res_status_in = dropped ? STAT_DROPPED : STAT_OK;
               state_in      = ST_DONE;
            end else if (l1 > r2) begin
               if (c1_ff == '0) begin
                  res_med_in    = '0;
                  res_status_in = STAT_NO_PART;
                  state_in      = ST_DONE;
               end else begin
                  hi_in    = LW'(c1_ff) - LW'(1);
                  state_in = ST_CUT;
               end
            end else begin
               lo_in    = LW'(c1_ff) + LW'(1);
               state_in = ST_CUT;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free, then clear the arrays
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_med_in    = res_med_ff;
               rsp_status_in = res_status_ff;
               ctl.clear     = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      sel_ff        <= sel_in;
      half_ff       <= half_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      left_short_ff <= left_short_in;
      left_long_ff  <= left_long_in;
      res_med_ff    <= res_med_in;
      res_status_ff <= res_status_in;
      rsp_med_ff    <= rsp_med_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = rsp_med_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire

// ----- rtl/median_of_two_sorted_arrays.sv -----
// Append items are accepted back to back while idle. A compute item with both
// arrays empty goes straight to the result; otherwise each binary search step cuts,
// reads both stores for the left and then the right neighbors, and evaluates. A
// search that runs out without a partition ends in one more cut. The result then
// goes to an output register, waiting while that register is full.
// Reset clears counts, drop flag and control; store contents are not cleared.
`default_nettype none

module median_of_two_sorted_arrays import medsa_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_action,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [MEDIAN_W-1:0]      rsp_median_doubled,
   output logic [1:0]                      rsp_status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]              first_count_ff, first_count_in;
   logic [CW-1:0]              second_count_ff, second_count_in;
   logic                       dropped_ff, dropped_in;
   logic                       accept, first_full, second_full;
   logic                       wr_first, wr_second, start;
   logic [AW-1:0]              rd_addr_first, rd_addr_second;
   logic signed [VALUE_W-1:0]  rd_data_first, rd_data_second;
   medsa_ctl_type              ctl;

   assign req_ready   = ctl.idle;
   assign accept      = req_valid && req_ready;
   assign first_full  = (first_count_ff == CW'(CAPACITY));
   assign second_full = (second_count_ff == CW'(CAPACITY));
   assign wr_first    = accept && req_action == ACT_LOAD_FIRST && !first_full;
   assign wr_second   = accept && req_action == ACT_LOAD_SECOND && !second_full;
   assign start       = accept && req_action == ACT_COMPUTE;

   // Advance counts on appends, flag drops, clear after a result
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      if (ctl.clear) begin
         first_count_in  = '0;
         second_count_in = '0;
         dropped_in      = 1'b0;
      end else begin
         if (wr_first) begin
            first_count_in = first_count_ff + CW'(1);
         end
         if (wr_second) begin
            second_count_in = second_count_ff + CW'(1);
         end
         if (accept && ((req_action == ACT_LOAD_FIRST && first_full) ||
                        (req_action == ACT_LOAD_SECOND && second_full))) begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
      end
   end

   medsa_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_first_store (
      .clock      (clock),
      .wr_en      (wr_first),
      .wr_addr    (first_count_ff[AW-1:0]),
      .wr_data    (req_value),
      .rd_addr    (rd_addr_first),
      .rd_data_ff (rd_data_first)
   );

   medsa_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_second_store (
      .clock      (clock),
      .wr_en      (wr_second),
      .wr_addr    (second_count_ff[AW-1:0]),
      .wr_data    (req_value),
      .rd_addr    (rd_addr_second),
      .rd_data_ff (rd_data_second)
   );

   medsa_ctrl #(
      .AW (AW),
      .CW (CW)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .n_first            (first_count_ff),
      .n_second           (second_count_ff),
      .dropped            (dropped_ff),
      .rd_addr_first      (rd_addr_first),
      .rd_addr_second     (rd_addr_second),
      .rd_data_first      (rd_data_first),
      .rd_data_second     (rd_data_second),
      .ctl                (ctl),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_status         (rsp_status)
   );

endmodule

`default_nettype wire
